// ===== hdl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk while rst_n is high.
`define NPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
  `NPS_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== hdl/nps_pkg.sv =====
// Shared constants and controller/datapath interface types for the sieve block.
package nps_pkg;

  localparam int SIEVE_BITS  = 131072;
  localparam int LIMIT_RESET = 131072;
  localparam int RANK_W      = 14;
  localparam int LIMIT_W     = 18;
  localparam int PRIME_W     = 17;
  localparam int KW          = $clog2(SIEVE_BITS) + 1;
  localparam int WORDS       = SIEVE_BITS / 64;
  localparam int WADDR_W     = $clog2(WORDS);
  localparam int ROOT_W      = ($clog2(SIEVE_BITS) + 1) / 2;

  typedef struct packed {
    logic init;
    logic emit_small;
    logic clear;
    logic load;
    logic grab;
    logic advance;
    logic count_up;
    logic mark_start;
    logic mark_rd;
    logic mark_wr;
    logic emit_found;
    logic emit_none;
  } nps_cmd_t;

  typedef struct packed {
    logic rank_small;
    logic clear_last;
    logic k_ge_bound;
    logic k_comp;
    logic k_word_end;
    logic count_hit;
    logic k_small;
    logic sq_lt_bound;
    logic m_end;
  } nps_stat_t;

endpackage

// ===== hdl/nps_ctrl.sv =====
// Sequencer that steps the sieve datapath through clear, walk and strike phases.
module nps_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output nps_pkg::nps_cmd_t cmd,
  input  nps_pkg::nps_stat_t stat
);
  import nps_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_LOAD  = 3'd2;
  localparam logic [2:0] S_GRAB  = 3'd3;
  localparam logic [2:0] S_TEST  = 3'd4;
  localparam logic [2:0] S_SQ    = 3'd5;
  localparam logic [2:0] S_MRD   = 3'd6;
  localparam logic [2:0] S_MWR   = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (stat.rank_small) begin
            cmd.emit_small = 1'b1;
          end else begin
            cmd.init  = 1'b1;
            state_nxt = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_GRAB;
      end
      S_GRAB: begin
        cmd.grab  = 1'b1;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (stat.k_ge_bound) begin
          cmd.emit_none = 1'b1;
          state_nxt     = S_IDLE;
        end else if (stat.k_comp) begin
          cmd.advance = 1'b1;
          state_nxt   = stat.k_word_end ? S_LOAD : S_TEST;
        end else begin
          cmd.count_up = 1'b1;
          if (stat.count_hit) begin
            cmd.emit_found = 1'b1;
            state_nxt      = S_IDLE;
          end else if (stat.k_small) begin
            state_nxt = S_SQ;
          end else begin
            cmd.advance = 1'b1;
            state_nxt   = stat.k_word_end ? S_LOAD : S_TEST;
          end
        end
      end
      S_SQ: begin
        if (stat.sq_lt_bound) begin
          cmd.mark_start = 1'b1;
          state_nxt      = S_MRD;
        end else begin
          cmd.advance = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      S_MRD: begin
        cmd.mark_rd = 1'b1;
        state_nxt   = S_MWR;
      end
      S_MWR: begin
        cmd.mark_wr = 1'b1;
        if (stat.m_end) begin
          // The word under test may have been struck, so it is read again.
          cmd.advance = 1'b1;
          state_nxt   = S_LOAD;
        end else begin
          state_nxt = S_MRD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/nps_datapath.sv =====
// Sieve datapath: odd-only composite bitmap, candidate walk, strike unit and result registers.
module nps_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [nps_pkg::LIMIT_W-1:0]   cfg_wdata,
  input  logic [nps_pkg::RANK_W-1:0]    in_target_rank,
  input  nps_pkg::nps_cmd_t             cmd,
  output nps_pkg::nps_stat_t            stat,
  output logic                          out_valid,
  output logic [nps_pkg::PRIME_W-1:0]   out_prime_value,
  output logic                          out_found
);
  import nps_pkg::*;

  // Bit i of the bitmap stands for the odd number 2*i+1.
  logic [31:0]         mem [WORDS];
  logic [31:0]         rdata_r;
  logic [WADDR_W-1:0]  raddr;
  logic [WADDR_W-1:0]  waddr;
  logic [31:0]         wdata;
  logic                we;

  logic [LIMIT_W-1:0]  limit_r, limit_nxt;
  logic [RANK_W-1:0]   rank_r, rank_nxt;
  logic [KW-1:0]       bound_r, bound_nxt;
  logic [KW-1:0]       k_r, k_nxt;
  logic [RANK_W-1:0]   count_r, count_nxt;
  logic [31:0]         word_r, word_nxt;
  logic [KW-1:0]       sq_r, sq_nxt;
  logic [KW-1:0]       m_r, m_nxt;
  logic [WADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [PRIME_W-1:0]  out_prime_r, out_prime_nxt;
  logic                out_found_r, out_found_nxt;

  logic [KW-1:0]       m_step;
  logic [RANK_W-1:0]   count_inc;
  logic [ROOT_W-1:0]   k_lo;
  logic [KW-1:0]       bound_in;

  assign m_step    = m_r + (k_r << 1);
  assign count_inc = count_r + RANK_W'(1);
  assign k_lo      = k_r[ROOT_W-1:0];
  assign bound_in  = (KW'(limit_r) > KW'(SIEVE_BITS)) ? KW'(SIEVE_BITS) : KW'(limit_r);

  assign stat.rank_small  = (in_target_rank < RANK_W'(3));
  assign stat.clear_last  = &clr_addr_r;
  assign stat.k_ge_bound  = (k_r >= bound_r);
  assign stat.k_comp      = word_r[k_r[5:1]];
  assign stat.k_word_end  = &k_r[5:1];
  assign stat.count_hit   = (count_inc == rank_r);
  assign stat.k_small     = (k_r[KW-1:ROOT_W] == '0);
  assign stat.sq_lt_bound = (sq_r < bound_r);
  assign stat.m_end       = (m_step >= bound_r);

  assign raddr = cmd.mark_rd ? m_r[WADDR_W+5:6] : k_r[WADDR_W+5:6];
  assign we    = cmd.clear | cmd.mark_wr;
  assign waddr = cmd.clear ? clr_addr_r : m_r[WADDR_W+5:6];
  assign wdata = cmd.clear ? 32'd0 : (rdata_r | (32'd1 << m_r[5:1]));

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_comb begin
    limit_nxt     = cfg_we ? cfg_wdata : limit_r;
    rank_nxt      = rank_r;
    bound_nxt     = bound_r;
    k_nxt         = k_r;
    count_nxt     = count_r;
    word_nxt      = cmd.grab ? rdata_r : word_r;
    sq_nxt        = KW'(k_lo) * KW'(k_lo);
    m_nxt         = m_r;
    clr_addr_nxt  = cmd.clear ? clr_addr_r + WADDR_W'(1) : clr_addr_r;
    out_valid_nxt = cmd.emit_small | cmd.emit_found | cmd.emit_none;
    out_prime_nxt = out_prime_r;
    out_found_nxt = out_found_r;

    if (cmd.init) begin
      rank_nxt     = in_target_rank;
      bound_nxt    = bound_in;
      k_nxt        = KW'(3);
      count_nxt    = RANK_W'(1);
      clr_addr_nxt = '0;
    end
    if (cmd.advance) begin
      k_nxt = k_r + KW'(2);
    end
    if (cmd.count_up) begin
      count_nxt = count_inc;
    end
    if (cmd.mark_start) begin
      m_nxt = sq_r;
    end
    if (cmd.mark_wr) begin
      m_nxt = m_step;
    end

    if (cmd.emit_small) begin
      // Rank zero has no prime; ranks one and two map to 2 and 3.
      out_found_nxt = (in_target_rank != '0);
      out_prime_nxt = out_found_nxt ? PRIME_W'(in_target_rank) + PRIME_W'(1) : '0;
    end else if (cmd.emit_found) begin
      out_found_nxt = 1'b1;
      out_prime_nxt = k_r[PRIME_W-1:0];
    end else if (cmd.emit_none) begin
      out_found_nxt = 1'b0;
      out_prime_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_W'(LIMIT_RESET);
      out_valid_r <= 1'b0;
    end else begin
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rank_r      <= rank_nxt;
    bound_r     <= bound_nxt;
    k_r         <= k_nxt;
    count_r     <= count_nxt;
    word_r      <= word_nxt;
    sq_r        <= sq_nxt;
    m_r         <= m_nxt;
    clr_addr_r  <= clr_addr_nxt;
    out_prime_r <= out_prime_nxt;
    out_found_r <= out_found_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_prime_value = out_prime_r;
  assign out_found       = out_found_r;

endmodule

// ===== hdl/nth_prime_sieve.sv =====
// Ranks 0 to 2 answer in the cycle after the request and never raise busy;
// other ranks first clear the whole bitmap, then test the odd candidates one
// at a time, loading each bitmap word before its candidates, and strike each
// multiple by a read-modify-write. One request at a time; for those ranks busy
// is high until the result strobe. Reset restores the limit to 131072 and leaves
// the bitmap as is, since every sieving request clears it first.
module nth_prime_sieve (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [nps_pkg::RANK_W-1:0]    in_target_rank,
  output logic                          out_valid,
  output logic [nps_pkg::PRIME_W-1:0]   out_prime_value,
  output logic                          out_found,
  input  logic                          cfg_we,
  input  logic [nps_pkg::LIMIT_W-1:0]   cfg_wdata
);
  import nps_pkg::*;

  nps_cmd_t  cmd;
  nps_stat_t stat;

  nps_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  nps_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_target_rank  (in_target_rank),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_prime_value (out_prime_value),
    .out_found       (out_found)
  );

endmodule

// ===== hdl/nps_checker.sv =====
// Port-level checker for the sieve block and its bind to the top level.
`include "assert_macros.svh"

module nps_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [nps_pkg::RANK_W-1:0]    in_target_rank,
  input logic                          out_valid,
  input logic [nps_pkg::PRIME_W-1:0]   out_prime_value,
  input logic                          out_found
);
  import nps_pkg::*;

  logic short_req;
  logic long_req;

  assign short_req  = start && !busy && (in_target_rank < RANK_W'(3));
  assign long_req   = start && !busy && (in_target_rank >= RANK_W'(3));

  `NPS_ASSERT_NEXT(a_short_answer, short_req, out_valid && !busy, "short request not answered")
  `NPS_ASSERT_NEXT(a_long_busy, long_req, busy && !out_valid, "sieve request did not go busy")
  `NPS_ASSERT(a_done_result, $past(rst_n) && $fell(busy) |-> out_valid, "busy fell without result")
  `NPS_ASSERT(a_miss_zero, out_valid && !out_found |-> out_prime_value == '0, "miss with nonzero value")
  `NPS_ASSERT(a_found_odd, out_valid && out_found && (out_prime_value != PRIME_W'(2)) |-> out_prime_value[0], "even prime above two")

endmodule

bind nth_prime_sieve nps_checker u_nps_checker (.*);
